FILE: rtl/a2rb_pkg.sv
// Shared constants and types for the Argon2 reference block index unit.
package a2rb_pkg;

    localparam int SLICE_COUNT_DEFAULT = 4;

    localparam int SEG_W = 21;
    localparam int LANES_W = 5;
    localparam int IDX_W = 26;
    localparam int WORD_W = 64;
    localparam int HALF_W = 32;
    localparam int CFG_IDX_W = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT_LENGTH = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_LANE_COUNT = CFG_IDX_W'(1);

    localparam logic [SEG_W-1:0] SEG_RESET = SEG_W'(262144);
    localparam logic [LANES_W-1:0] LANES_RESET = LANES_W'(4);

    typedef struct packed {
        logic en;
        logic valid;
    } pipe_ctl_t;

endpackage

FILE: rtl/a2rb_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
module a2rb_div #(
    parameter int N = 32,
    parameter int D = 8,
    parameter int Q = 32,
    parameter int S = 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  a2rb_pkg::pipe_ctl_t ctl,
    input  logic [N-1:0]        dividend,
    input  logic [D-1:0]        divisor,
    input  logic [S-1:0]        in_side,
    output logic                out_valid,
    output logic [Q-1:0]        out_quot,
    output logic [D-1:0]        out_rem,
    output logic [S-1:0]        out_side
);

    localparam int W = N + D;

    logic [Q-1:0] vld_reg;
    logic [N-1:0] rem_reg  [Q];
    logic [Q-1:0] quot_reg [Q];
    logic [S-1:0] side_reg [Q];

    for (genvar j = 0; j < Q; j++) begin : g_stage
        localparam int B = Q - 1 - j;
        logic         src_v;
        logic [N-1:0] src_rem;
        logic [Q-1:0] src_quot;
        logic [S-1:0] src_side;
        logic [W-1:0] shifted;
        logic [W-1:0] wide_rem;
        logic [W-1:0] diff;
        logic         fits;
        logic [N-1:0] rem_next;
        logic [Q-1:0] quot_next;

        if (j == 0) begin : g_first
            assign src_v = ctl.valid;
            assign src_rem = dividend;
            assign src_quot = '0;
            assign src_side = in_side;
        end
        else begin : g_rest
            assign src_v = vld_reg[j-1];
            assign src_rem = rem_reg[j-1];
            assign src_quot = quot_reg[j-1];
            assign src_side = side_reg[j-1];
        end

        assign shifted = W'(divisor) << B;
        assign wide_rem = W'(src_rem);
        assign fits = wide_rem >= shifted;
        assign diff = wide_rem - shifted;

        always_comb
        begin
            rem_next = fits ? diff[N-1:0] : src_rem;
            quot_next = src_quot;
            quot_next[B] = fits;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[j] <= 1'b0;
            end
            else if (ctl.en)
            begin
                vld_reg[j] <= src_v;
            end
        end

        always_ff @(posedge clk)
        begin
            if (ctl.en)
            begin
                rem_reg[j] <= rem_next;
                quot_reg[j] <= quot_next;
                side_reg[j] <= src_side;
            end
        end
    end

    assign out_valid = vld_reg[Q-1];
    assign out_quot = quot_reg[Q-1];
    assign out_rem = rem_reg[Q-1][D-1:0];
    assign out_side = side_reg[Q-1];

endmodule

FILE: rtl/argon2_reference_block_index.sv
// Top level of the Argon2 reference block index unit.
//
//   Channel | Handshake             | Payload
//   --------+-----------------------+--------------------------------------------
//   cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data
//   in      | in_valid / in_stall   | block_index, opening_word, later_pass
//   out     | out_valid / out_stall | pred_index, ref_block_index
//
// One item enters per cycle while in_stall is low, and each passes through the four
// bit-per-stage dividers and the multiply stages between them.
// Reset clears the configuration to its defaults and empties the pipeline.
// The pipeline stops only when the output skid register holds a transfer, so in_stall
// is a registered signal and a stalled output loses and repeats nothing.
module argon2_reference_block_index #(
    parameter int SLICE_COUNT = a2rb_pkg::SLICE_COUNT_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [a2rb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [a2rb_pkg::SEG_W-1:0]       cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [a2rb_pkg::IDX_W-1:0]       block_index,
    input  logic [a2rb_pkg::WORD_W-1:0]      opening_word,
    input  logic                             later_pass,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [a2rb_pkg::IDX_W-1:0]       pred_index,
    output logic [a2rb_pkg::IDX_W-1:0]       ref_block_index
);

    localparam int SL_W = $clog2(SLICE_COUNT);
    localparam int LL_W = a2rb_pkg::SEG_W + SL_W;
    localparam int IDX_W = a2rb_pkg::IDX_W;
    localparam int HALF_W = a2rb_pkg::HALF_W;
    localparam int LANES_W = a2rb_pkg::LANES_W;
    localparam int SEG_W = a2rb_pkg::SEG_W;

    typedef struct packed {
        logic [IDX_W-1:0]  ij;
        logic [HALF_W-1:0] pr;
        logic              later;
    } item_t;

    typedef struct packed {
        item_t             item;
        logic [LANES_W-1:0] rlr;
    } a_side_t;

    typedef struct packed {
        item_t              item;
        logic [LANES_W-1:0] rlr;
        logic [IDX_W-1:0]   lane;
    } b_side_t;

    typedef struct packed {
        logic [IDX_W-1:0] prev;
        logic [IDX_W-1:0] base;
    } f_side_t;

    logic [SEG_W-1:0]   seg_reg;
    logic [LANES_W-1:0] lanes_reg;
    logic [SEG_W-1:0]   seg_eff;
    logic [LANES_W-1:0] lanes_eff;
    logic [LL_W-1:0]    lane_len;

    logic               skid_valid_reg;
    logic               en;
    a2rb_pkg::pipe_ctl_t ctl_m, ctl_a, ctl_b, ctl_f;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_reg <= a2rb_pkg::SEG_RESET;
            lanes_reg <= a2rb_pkg::LANES_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                a2rb_pkg::CFG_SEGMENT_LENGTH: seg_reg <= cfg_data;
                a2rb_pkg::CFG_LANE_COUNT:     lanes_reg <= cfg_data[LANES_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;
    assign seg_eff = (seg_reg == '0) ? SEG_W'(1) : seg_reg;
    assign lanes_eff = (lanes_reg == '0) ? LANES_W'(1) : lanes_reg;
    assign lane_len = LL_W'(seg_eff) * LL_W'(SLICE_COUNT);

    assign en = !skid_valid_reg;
    assign in_stall = skid_valid_reg;

    // Lane pick: high word half modulo the lane count.
    item_t   m_in;
    a_side_t a_in;
    logic    m_out_valid;
    item_t   m_out;
    logic [LANES_W-1:0] m_rem;

    assign m_in.ij = block_index;
    assign m_in.pr = opening_word[HALF_W-1:0];
    assign m_in.later = later_pass;
    assign ctl_m.en = en;
    assign ctl_m.valid = in_valid && !in_stall;

    a2rb_div #(.N(HALF_W), .D(LANES_W), .Q(HALF_W), .S($bits(item_t))) u_div_lane (
        .clk(clk), .rst_n(rst_n), .ctl(ctl_m),
        .dividend(opening_word[a2rb_pkg::WORD_W-1:HALF_W]),
        .divisor(lanes_eff), .in_side(m_in),
        .out_valid(m_out_valid), .out_quot(), .out_rem(m_rem), .out_side(m_out)
    );

    // Split of the flat index into lane and offset within the lane.
    logic             a_out_valid;
    logic [IDX_W-1:0] a_quot;
    logic [LL_W-1:0]  a_rem;
    a_side_t          a_out;
    b_side_t          b_in;

    assign a_in.item = m_out;
    assign a_in.rlr = m_rem;
    assign ctl_a.en = en;
    assign ctl_a.valid = m_out_valid;

    a2rb_div #(.N(IDX_W), .D(LL_W), .Q(IDX_W), .S($bits(a_side_t))) u_div_index (
        .clk(clk), .rst_n(rst_n), .ctl(ctl_a),
        .dividend(m_out.ij), .divisor(lane_len), .in_side(a_in),
        .out_valid(a_out_valid), .out_quot(a_quot), .out_rem(a_rem), .out_side(a_out)
    );

    // Split of the lane offset into slice and position.
    logic             b_out_valid;
    logic [SL_W-1:0]  slice;
    logic [SEG_W-1:0] idx;
    b_side_t          b_out;

    assign b_in.item = a_out.item;
    assign b_in.rlr = a_out.rlr;
    assign b_in.lane = a_quot;
    assign ctl_b.en = en;
    assign ctl_b.valid = a_out_valid;

    a2rb_div #(.N(LL_W), .D(SEG_W), .Q(SL_W), .S($bits(b_side_t))) u_div_slice (
        .clk(clk), .rst_n(rst_n), .ctl(ctl_b),
        .dividend(a_rem), .divisor(seg_eff), .in_side(b_in),
        .out_valid(b_out_valid), .out_quot(slice), .out_rem(idx), .out_side(b_out)
    );

    // Reference area, start offset and squaring of the low word half.
    logic [IDX_W-1:0]  ref_lane_next;
    logic [31:0]       slice_seg;
    logic [31:0]       edge_term;
    logic [31:0]       lane_less;
    logic [31:0]       area_next;
    logic [LL_W-1:0]   start_next;
    logic [63:0]       square;
    logic [31:0]       prev_wide;
    logic [IDX_W-1:0]  prev_next;

    logic              c1_valid_reg;
    logic [31:0]       c1_area_reg;
    logic [LL_W-1:0]   c1_start_reg;
    logic [31:0]       c1_x_reg;
    logic [IDX_W-1:0]  c1_prev_reg;
    logic [IDX_W-1:0]  c1_ref_lane_reg;

    always_comb
    begin
        ref_lane_next = (slice == '0) ? b_out.lane : IDX_W'(b_out.rlr);
        slice_seg = 32'(slice) * 32'(seg_eff);
        edge_term = (idx == '0) ? 32'hFFFF_FFFF : 32'd0;
        lane_less = 32'(lane_len) - 32'(seg_eff);
        start_next = '0;
        if (!b_out.item.later)
        begin
            if (slice == '0)
                area_next = 32'(idx) - 32'd1;
            else if (ref_lane_next == b_out.lane)
                area_next = slice_seg + 32'(idx) - 32'd1;
            else
                area_next = slice_seg + edge_term;
        end
        else
        begin
            if (ref_lane_next == b_out.lane)
                area_next = lane_less + 32'(idx) - 32'd1;
            else
                area_next = lane_less + edge_term;
            if (slice != SL_W'(SLICE_COUNT - 1))
                start_next = LL_W'((SL_W + 1)'(slice) + (SL_W + 1)'(1)) * LL_W'(seg_eff);
        end
        square = 64'(b_out.item.pr) * 64'(b_out.item.pr);
        if (slice == '0 && idx == '0)
            prev_wide = 32'(b_out.item.ij) + 32'(lane_len) - 32'd1;
        else
            prev_wide = 32'(b_out.item.ij) - 32'd1;
        prev_next = prev_wide[IDX_W-1:0];
    end

    // Area scaling and lane base.
    logic [63:0]      scaled;
    logic [IDX_W-1:0] base_next;
    logic             c2_valid_reg;
    logic [31:0]      c2_area_reg;
    logic [31:0]      c2_hi_reg;
    logic [LL_W-1:0]  c2_start_reg;
    logic [IDX_W-1:0] c2_prev_reg;
    logic [IDX_W-1:0] c2_base_reg;

    assign scaled = 64'(c1_area_reg) * 64'(c1_x_reg);
    assign base_next = IDX_W'(lane_len) * c1_ref_lane_reg;

    // Relative position plus start offset.
    logic [31:0]      rel;
    logic [32:0]      sum_next;
    logic             c3_valid_reg;
    logic [32:0]      c3_sum_reg;
    f_side_t          c3_side_reg;
    f_side_t          c3_side_next;

    assign rel = (c2_area_reg - 32'd1) - c2_hi_reg;
    assign sum_next = 33'(c2_start_reg) + 33'(rel);
    assign c3_side_next.prev = c2_prev_reg;
    assign c3_side_next.base = c2_base_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_valid_reg <= 1'b0;
            c2_valid_reg <= 1'b0;
            c3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            c1_valid_reg <= b_out_valid;
            c2_valid_reg <= c1_valid_reg;
            c3_valid_reg <= c2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c1_area_reg <= area_next;
            c1_start_reg <= start_next;
            c1_x_reg <= square[63:32];
            c1_prev_reg <= prev_next;
            c1_ref_lane_reg <= ref_lane_next;
            c2_area_reg <= c1_area_reg;
            c2_hi_reg <= scaled[63:32];
            c2_start_reg <= c1_start_reg;
            c2_prev_reg <= c1_prev_reg;
            c2_base_reg <= base_next;
            c3_sum_reg <= sum_next;
            c3_side_reg <= c3_side_next;
        end
    end

    // Reduction modulo the lane length.
    logic            f_out_valid;
    logic [LL_W-1:0] pos;
    f_side_t         f_out;

    assign ctl_f.en = en;
    assign ctl_f.valid = c3_valid_reg;

    a2rb_div #(.N(33), .D(LL_W), .Q(33), .S($bits(f_side_t))) u_div_wrap (
        .clk(clk), .rst_n(rst_n), .ctl(ctl_f),
        .dividend(c3_sum_reg), .divisor(lane_len), .in_side(c3_side_reg),
        .out_valid(f_out_valid), .out_quot(), .out_rem(pos), .out_side(f_out)
    );

    logic             p_valid_reg;
    logic [IDX_W-1:0] p_prev_reg;
    logic [IDX_W-1:0] p_ref_reg;
    logic [IDX_W-1:0] p_ref_next;

    assign p_ref_next = f_out.base + IDX_W'(pos);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            p_valid_reg <= f_out_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_prev_reg <= f_out.prev;
            p_ref_reg <= p_ref_next;
        end
    end

    // Output register with a skid entry behind it.
    logic             out_valid_reg;
    logic [IDX_W-1:0] out_prev_reg;
    logic [IDX_W-1:0] out_ref_reg;
    logic [IDX_W-1:0] skid_prev_reg;
    logic [IDX_W-1:0] skid_ref_reg;
    logic             pop;
    logic             push;

    assign pop = out_valid_reg && !out_stall;
    assign push = en && p_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
                skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
                skid_valid_reg <= 1'b1;
            else
                out_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_prev_reg <= skid_prev_reg;
                out_ref_reg <= skid_ref_reg;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_prev_reg <= p_prev_reg;
                skid_ref_reg <= p_ref_reg;
            end
            else
            begin
                out_prev_reg <= p_prev_reg;
                out_ref_reg <= p_ref_reg;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign pred_index = out_prev_reg;
    assign ref_block_index = out_ref_reg;

endmodule

FILE: verif/tb_top.sv
// Self-checking testbench for the Argon2 reference block index unit.
`timescale 1ns / 100ps

class index_scoreboard;
    logic [25:0] pending_prev[$];
    logic [25:0] pending_ref[$];
    int          errors;
    logic [20:0] seg_len_reg;
    logic [4:0]  lanes_reg;

    function void reset_config();
        seg_len_reg = a2rb_pkg::SEG_RESET;
        lanes_reg   = a2rb_pkg::LANES_RESET;
        errors      = 0;
    endfunction

    function void note_input(logic [25:0] bi, logic [63:0] ow, logic lp);
        logic [31:0] seg, lanes, lane_len, ij, prev, rlane, pr, lane, slice, idx;
        logic [31:0] area, start, edge_off, pos, refb;
        logic [63:0] x, rel, sum;
        seg      = (seg_len_reg == 0) ? 32'd1 : 32'(seg_len_reg);
        lanes    = (lanes_reg == 0) ? 32'd1 : 32'(lanes_reg);
        lane_len = seg * 32'(a2rb_pkg::SLICE_COUNT_DEFAULT);
        ij       = 32'(bi);
        prev     = (ij % lane_len == 0) ? ij + lane_len - 32'd1 : ij - 32'd1;
        rlane    = 32'(ow[63:32] % 64'(lanes));
        pr       = ow[31:0];
        lane     = ij / lane_len;
        slice    = (ij - lane * lane_len) / seg;
        idx      = ij - lane * lane_len - slice * seg;
        if (slice == 0)
            rlane = lane;
        edge_off = (idx == 0) ? 32'hFFFF_FFFF : 32'd0;
        start    = 32'd0;
        if (!lp)
        begin
            if (slice == 0)
                area = idx - 32'd1;
            else if (rlane == lane)
                area = slice * seg + idx - 32'd1;
            else
                area = slice * seg + edge_off;
        end
        else
        begin
            if (rlane == lane)
                area = lane_len - seg + idx - 32'd1;
            else
                area = lane_len - seg + edge_off;
            start = (slice == 32'(a2rb_pkg::SLICE_COUNT_DEFAULT - 1)) ? 32'd0
                  : (slice + 32'd1) * seg;
        end
        x    = (64'(pr) * 64'(pr)) >> 32;
        rel  = 64'(32'(area - 32'd1)) - ((64'(area) * x) >> 32);
        sum  = (64'(start) + rel) % 64'(lane_len);
        pos  = sum[31:0];
        refb = lane_len * rlane + pos;
        pending_prev.push_back(prev[25:0]);
        pending_ref.push_back(refb[25:0]);
    endfunction

    function void check_result(logic [25:0] p, logic [25:0] r);
        logic [25:0] ep, er;
        if (pending_prev.size() == 0)
        begin
            $error("unexpected result pred_index=%0d ref_block_index=%0d", p, r);
            errors++;
            return;
        end
        ep = pending_prev.pop_front();
        er = pending_ref.pop_front();
        if (ep !== p)
        begin
            $error("pred_index expected %0d actual %0d", ep, p);
            errors++;
        end
        if (er !== r)
        begin
            $error("ref_block_index expected %0d actual %0d", er, r);
            errors++;
        end
    endfunction
endclass

module tb_top;
    localparam int CFG_IDX_W = a2rb_pkg::CFG_IDX_W;
    localparam int SEG_W = a2rb_pkg::SEG_W;
    localparam int IDX_W = a2rb_pkg::IDX_W;
    localparam int WORD_W = a2rb_pkg::WORD_W;
    localparam int LANES_W = a2rb_pkg::LANES_W;
    localparam int SLICES = a2rb_pkg::SLICE_COUNT_DEFAULT;
    localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT_LENGTH = a2rb_pkg::CFG_SEGMENT_LENGTH;
    localparam logic [CFG_IDX_W-1:0] CFG_LANE_COUNT = a2rb_pkg::CFG_LANE_COUNT;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [SEG_W-1:0]     cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    logic [IDX_W-1:0]     block_index;
    logic [WORD_W-1:0]    opening_word;
    logic                 later_pass;
    logic                 out_valid;
    logic                 out_stall;
    logic [IDX_W-1:0]     pred_index;
    logic [IDX_W-1:0]     ref_block_index;

    index_scoreboard sb;
    int  idle_cycles;
    bit  stall_mode;
    localparam int LATENCY = 100;
    localparam int WATCHDOG_LIMIT = 20000;

    argon2_reference_block_index i_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .block_index(block_index), .opening_word(opening_word),
        .later_pass(later_pass),
        .out_valid(out_valid), .out_stall(out_stall),
        .pred_index(pred_index), .ref_block_index(ref_block_index)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(pred_index, ref_block_index);
        if (rst_n && ((in_valid && !in_stall) || (out_valid && !out_stall)))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if ($urandom_range(0, 63) == 0)
            stall_mode <= ~stall_mode;
        out_stall <= stall_mode ? ($urandom_range(0, 2) != 0) : 1'b0;
    end

    always @(posedge clk)
    begin
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] ri, logic [SEG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= ri;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (ri == CFG_SEGMENT_LENGTH)
            sb.seg_len_reg = val;
        else
            sb.lanes_reg = val[LANES_W-1:0];
    endtask

    task automatic send_item(logic [IDX_W-1:0] bi, logic [WORD_W-1:0] ow, logic lp);
        in_valid     <= 1'b1;
        block_index  <= bi;
        opening_word <= ow;
        later_pass   <= lp;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_input(bi, ow, lp);
    endtask

    task automatic gap();
        if ($urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending_prev.size() != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    function automatic logic [WORD_W-1:0] rand_word();
        return {$urandom(), $urandom()};
    endfunction

    task automatic random_phase(int count, int seg);
        int lane_len;
        lane_len = seg * SLICES;
        for (int k = 0; k < count; k++)
        begin
            logic [IDX_W-1:0] bi;
            case ($urandom_range(0, 3))
                0: bi = IDX_W'($urandom());
                1: bi = IDX_W'($urandom_range(0, 4 * lane_len - 1));
                2: bi = IDX_W'($urandom_range(0, 3) * lane_len
                        + $urandom_range(0, SLICES - 1) * seg + $urandom_range(0, 2));
                default: bi = IDX_W'($urandom_range(0, 17 * lane_len - 1));
            endcase
            send_item(bi, rand_word(), 1'($urandom_range(0, 1)));
            gap();
        end
    endtask

    initial
    begin
        int segs[6];
        int lanes_set[6];
        sb = new();
        sb.reset_config();
        idle_cycles  = 0;
        stall_mode   = 1'b0;
        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        block_index  = '0;
        opening_word = '0;
        later_pass   = 1'b0;
        out_stall    = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item('0, '0, 1'b0);
        send_item(26'h3FF_FFFF, '1, 1'b1);
        send_item(26'd1, 64'h0000_0005_FFFF_FFFF, 1'b0);
        send_item(26'd262144, rand_word(), 1'b0);
        send_item(26'd262144 * 5, rand_word(), 1'b1);
        send_item(26'd1048576, '1, 1'b0);
        send_item(26'd786432, 64'h5555_5555_AAAA_AAAA, 1'b1);
        send_item(26'd524288, 64'hAAAA_AAAA_5555_5555, 1'b0);
        drain();

        write_reg(CFG_SEGMENT_LENGTH, 21'd0);
        write_reg(CFG_LANE_COUNT, 21'd0);
        for (int k = 0; k < 12; k++)
            send_item(IDX_W'(k), rand_word(), k[0]);
        drain();

        segs      = '{1, 3, 16, 1048576, 2047, 1};
        lanes_set = '{16, 3, 5, 2, 31, 1};
        for (int ph = 0; ph < 6; ph++)
        begin
            write_reg(CFG_SEGMENT_LENGTH, SEG_W'(segs[ph]));
            write_reg(CFG_LANE_COUNT, SEG_W'(lanes_set[ph]));
            random_phase(170, segs[ph]);
            drain();
        end

        if (sb.errors == 0 && sb.pending_prev.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
